>>> hdl/capacitance_level_piecewise_calibrator_macros.svh
// Assertion macros used by the checker of the level calibrator.
`ifndef CAPACITANCE_LEVEL_PIECEWISE_CALIBRATOR_MACROS_SVH
`define CAPACITANCE_LEVEL_PIECEWISE_CALIBRATOR_MACROS_SVH

// Same-cycle implication, switched off during reset.
`define CLPC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("calibrator check failed");

// Next-cycle implication, switched off during reset.
`define CLPC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("calibrator check failed");

// Next-cycle implication that also holds through reset.
`define CLPC_ASSERT_ALW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("calibrator check failed");

`endif

>>> hdl/clpc_pkg.sv
package clpc_pkg;

    localparam int unsigned DAC_LOW    = 0;
    localparam int unsigned DAC_HIGH   = 4095;
    localparam int unsigned LEVEL_FULL = 65535;

    localparam logic [15:0] DAC_LOW_C    = 16'(DAC_LOW);
    localparam logic [15:0] LEVEL_FULL_C = 16'(LEVEL_FULL);
    localparam logic [15:0] LIN_RANGE    = (DAC_HIGH > DAC_LOW) ? 16'(DAC_HIGH - DAC_LOW) : 16'd0;
    localparam logic [15:0] DAC_TOP      = (DAC_HIGH > DAC_LOW) ? 16'(DAC_HIGH) : 16'(DAC_LOW);

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned RAW_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COMP_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_EMPTY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_FULL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SPAN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_BP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_BP       = 3'd7;

    localparam int unsigned DIV1_NUM_W = 56;
    localparam int unsigned DIV1_DEN_W = 32;
    localparam int unsigned DIV1_Q_W   = 24;
    localparam int unsigned DIV1_LANES = 4;
    localparam int unsigned DIV2_NUM_W = 32;
    localparam int unsigned DIV2_DEN_W = 16;
    localparam int unsigned DIV2_Q_W   = 16;

    typedef struct packed {
        logic        valid;
        logic [31:0] corr;
    } t_corr;

    typedef struct packed {
        logic [15:0] level;
        logic [23:0] height;
        logic [15:0] lin;
        logic [15:0] direct;
        logic        hold;
        logic [15:0] hval;
        logic [15:0] dlo;
        logic        down;
    } t_cal_side;

endpackage

>>> hdl/clpc_corr.sv
module clpc_corr (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [clpc_pkg::RAW_W-1:0]  i_raw,
    input  logic                        i_comp_enable,
    input  logic [15:0]                 i_gain,
    input  logic [15:0]                 i_offset,
    output clpc_pkg::t_corr             o_corr
);
    import clpc_pkg::*;

    localparam logic [1:0] MODE_BYPASS = 2'd0;
    localparam logic [1:0] MODE_ZERO   = 2'd1;
    localparam logic [1:0] MODE_SAT    = 2'd2;
    localparam logic [1:0] MODE_DIV    = 2'd3;
    localparam logic [47:0] BIAS    = 48'd10000;
    localparam logic [47:0] SAT_LIM = 48'd429496729600;
    localparam int unsigned STEPS = 4;

    function automatic logic [14:0] div100_byte(input logic [6:0] rem_in, input logic [7:0] bits);
        logic [6:0] rem;
        logic [7:0] acc;
        logic [7:0] quo;
        rem = rem_in;
        quo = '0;
        for (int i = 7; i >= 0; i--) begin
            acc = {rem, bits[i]};
            if (acc >= 8'd100) begin
                quo[i] = 1'b1;
                rem    = 7'(acc - 8'd100);
            end else begin
                rem = acc[6:0];
            end
        end
        return {rem, quo};
    endfunction

    logic        r_a_valid;
    logic [47:0] r_a_t;
    logic [31:0] r_a_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
        if (i_en) begin
            r_a_t   <= 48'(i_raw) * 48'(i_gain) + 48'(i_offset);
            r_a_raw <= i_raw;
        end
    end

    logic        r_b_valid;
    logic [1:0]  r_b_mode;
    logic [38:0] r_b_u;
    logic [1:0]  n_b_mode;
    logic [38:0] n_b_u;
    logic [47:0] w_diff;

    always_comb begin
        w_diff = r_a_t - BIAS;
        if (!i_comp_enable) begin
            n_b_mode = MODE_BYPASS;
            n_b_u    = {7'd0, r_a_raw};
        end else if (r_a_t < BIAS) begin
            n_b_mode = MODE_ZERO;
            n_b_u    = '0;
        end else if (w_diff >= SAT_LIM) begin
            n_b_mode = MODE_SAT;
            n_b_u    = '0;
        end else begin
            n_b_mode = MODE_DIV;
            n_b_u    = w_diff[38:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
        if (i_en) begin
            r_b_mode <= n_b_mode;
            r_b_u    <= n_b_u;
        end
    end

    logic [STEPS-1:0] r_c_valid;
    logic [1:0]       r_c_mode [STEPS];
    logic [6:0]       r_c_rem  [STEPS];
    logic [31:0]      r_c_low  [STEPS];
    logic [31:0]      r_c_quo  [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic        w_valid;
        logic [1:0]  w_mode;
        logic [6:0]  w_rem;
        logic [31:0] w_low;
        logic [31:0] w_quo;
        logic [14:0] w_res;
        if (s == 0) begin : g_first
            assign w_valid = r_b_valid;
            assign w_mode  = r_b_mode;
            assign w_rem   = r_b_u[38:32];
            assign w_low   = r_b_u[31:0];
            assign w_quo   = '0;
        end else begin : g_next
            assign w_valid = r_c_valid[s-1];
            assign w_mode  = r_c_mode[s-1];
            assign w_rem   = r_c_rem[s-1];
            assign w_low   = r_c_low[s-1];
            assign w_quo   = r_c_quo[s-1];
        end
        assign w_res = div100_byte(w_rem, w_low[31-8*s -: 8]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_c_valid[s] <= w_valid;
            end
            if (i_en) begin
                r_c_mode[s] <= w_mode;
                r_c_rem[s]  <= w_res[14:8];
                r_c_low[s]  <= w_low;
                r_c_quo[s]  <= {w_quo[23:0], w_res[7:0]};
            end
        end
    end

    logic        r_d_valid;
    logic [31:0] r_d_corr;
    logic [31:0] n_d_corr;

    always_comb begin
        case (r_c_mode[STEPS-1])
            MODE_BYPASS: n_d_corr = r_c_low[STEPS-1];
            MODE_ZERO:   n_d_corr = '0;
            MODE_SAT:    n_d_corr = '1;
            default:     n_d_corr = r_c_quo[STEPS-1];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid <= r_c_valid[STEPS-1];
        end
        if (i_en) begin
            r_d_corr <= n_d_corr;
        end
    end

    assign o_corr.valid = r_d_valid;
    assign o_corr.corr  = r_d_corr;

endmodule

>>> hdl/clpc_div.sv
module clpc_div #(
    parameter int unsigned NUM_W  = 56,
    parameter int unsigned DEN_W  = 32,
    parameter int unsigned Q_W    = 24,
    parameter int unsigned LANES  = 1,
    parameter int unsigned SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][NUM_W-1:0] i_num,
    input  logic [LANES-1:0][DEN_W-1:0] i_den,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [LANES-1:0][Q_W-1:0]   o_quo,
    output logic [SIDE_W-1:0]           o_side
);
    import clpc_pkg::*;

    logic [Q_W-1:0]                  r_valid;
    logic [LANES-1:0][NUM_W-1:0]     r_rem  [Q_W];
    logic [LANES-1:0][DEN_W-1:0]     r_den  [Q_W];
    logic [LANES-1:0][Q_W-1:0]       r_quo  [Q_W];
    logic [SIDE_W-1:0]               r_side [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic                        w_valid;
        logic [LANES-1:0][NUM_W-1:0] w_rem;
        logic [LANES-1:0][DEN_W-1:0] w_den;
        logic [LANES-1:0][Q_W-1:0]   w_quo;
        logic [SIDE_W-1:0]           w_side;
        logic [LANES-1:0][NUM_W-1:0] n_rem;
        logic [LANES-1:0][Q_W-1:0]   n_quo;
        logic [NUM_W-1:0]            w_sub;
        if (s == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_rem   = i_num;
            assign w_den   = i_den;
            assign w_quo   = '0;
            assign w_side  = i_side;
        end else begin : g_next
            assign w_valid = r_valid[s-1];
            assign w_rem   = r_rem[s-1];
            assign w_den   = r_den[s-1];
            assign w_quo   = r_quo[s-1];
            assign w_side  = r_side[s-1];
        end

        always_comb begin
            w_sub = '0;
            for (int l = 0; l < LANES; l++) begin
                w_sub = NUM_W'(w_den[l]) << (Q_W - 1 - s);
                if (w_rem[l] >= w_sub) begin
                    n_rem[l] = w_rem[l] - w_sub;
                    n_quo[l] = {w_quo[l][Q_W-2:0], 1'b1};
                end else begin
                    n_rem[l] = w_rem[l];
                    n_quo[l] = {w_quo[l][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= w_valid;
            end
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_den[s]  <= w_den;
                r_quo[s]  <= n_quo;
                r_side[s] <= w_side;
            end
        end
    end

    assign o_valid = r_valid[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

>>> hdl/capacitance_level_piecewise_calibrator.sv
// Channel  | Direction | Handshake                  | Words
// input    | in        | i_valid / o_stall          | i_raw_reading
// output   | out       | o_valid / i_stall          | level, height, linear and calibrated DAC
// config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One word is accepted in every cycle unless a stalled output word holds the pipeline.
// The pipeline runs through two restoring dividers, 24 and 16 stages long.
// Reset is synchronous and clears the valid bits and the config registers to their defaults.
// A stalled output word freezes the whole pipeline, so nothing is lost or repeated.
module capacitance_level_piecewise_calibrator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [31:0]                     i_raw_reading,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [15:0]                     o_level_code,
    output logic [23:0]                     o_height_q8,
    output logic [15:0]                     o_dac_linear,
    output logic [15:0]                     o_dac_calibrated,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [clpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [clpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import clpc_pkg::*;

    logic        r_comp_enable;
    logic [15:0] r_gain;
    logic [15:0] r_offset;
    logic [31:0] r_cap_empty;
    logic [31:0] r_cap_full;
    logic [15:0] r_height_span;
    logic [63:0] r_level_bp;
    logic [63:0] r_dac_bp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp_enable <= 1'b0;
            r_gain        <= 16'd100;
            r_offset      <= 16'd10000;
            r_cap_empty   <= '0;
            r_cap_full    <= '1;
            r_height_span <= '0;
            r_level_bp    <= '0;
            r_dac_bp      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COMP_ENABLE: r_comp_enable <= i_cfg_data[0];
                CFG_GAIN:        r_gain        <= i_cfg_data[15:0];
                CFG_OFFSET:      r_offset      <= i_cfg_data[15:0];
                CFG_CAP_EMPTY:   r_cap_empty   <= i_cfg_data[31:0];
                CFG_CAP_FULL:    r_cap_full    <= i_cfg_data[31:0];
                CFG_HEIGHT_SPAN: r_height_span <= i_cfg_data[15:0];
                CFG_LEVEL_BP:    r_level_bp    <= i_cfg_data;
                CFG_DAC_BP:      r_dac_bp      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_o_valid;
    logic w_en;

    assign w_en    = !(r_o_valid && i_stall);
    assign o_stall = !w_en;

    logic [15:0] a0, a1, a2, a3, d0, d1, d2, d3;
    assign a0 = r_level_bp[15:0];
    assign a1 = r_level_bp[31:16];
    assign a2 = r_level_bp[47:32];
    assign a3 = r_level_bp[63:48];
    assign d0 = r_dac_bp[15:0];
    assign d1 = r_dac_bp[31:16];
    assign d2 = r_dac_bp[47:32];
    assign d3 = r_dac_bp[63:48];

    logic        w_span_pos;
    logic [31:0] w_span;
    logic        w_dir_down;
    logic [15:0] w_mag03;
    logic        w_uncal;

    assign w_span_pos = r_cap_full > r_cap_empty;
    assign w_span     = r_cap_full - r_cap_empty;
    assign w_dir_down = d3 < d0;
    assign w_mag03    = w_dir_down ? (d0 - d3) : (d3 - d0);
    assign w_uncal    = (a1 == 16'd0) || (d2 == 16'd0);

    t_corr w_corr;

    clpc_corr u_corr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_valid),
        .i_raw         (i_raw_reading),
        .i_comp_enable (r_comp_enable),
        .i_gain        (r_gain),
        .i_offset      (r_offset),
        .o_corr        (w_corr)
    );

    logic        r_n_valid;
    logic        r_n_szero;
    logic [31:0] r_n_num;
    logic [31:0] n_n_num;

    always_comb begin
        if (!w_span_pos || (w_corr.corr <= r_cap_empty)) begin
            n_n_num = '0;
        end else if (w_corr.corr >= r_cap_full) begin
            n_n_num = w_span;
        end else begin
            n_n_num = w_corr.corr - r_cap_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (w_en) begin
            r_n_valid <= w_corr.valid;
        end
        if (w_en) begin
            r_n_num   <= n_n_num;
            r_n_szero <= !w_span_pos;
        end
    end

    logic                                    r_p_valid;
    logic                                    r_p_szero;
    logic [DIV1_LANES-1:0][DIV1_NUM_W-1:0]   r_p_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= r_n_valid;
        end
        if (w_en) begin
            r_p_szero  <= r_n_szero;
            r_p_num[0] <= DIV1_NUM_W'(r_n_num) * DIV1_NUM_W'(LEVEL_FULL_C);
            r_p_num[1] <= (DIV1_NUM_W'(r_n_num) * DIV1_NUM_W'(r_height_span)) << 8;
            r_p_num[2] <= DIV1_NUM_W'(r_n_num) * DIV1_NUM_W'(LIN_RANGE);
            r_p_num[3] <= DIV1_NUM_W'(r_n_num) * DIV1_NUM_W'(w_mag03);
        end
    end

    logic                                    w_q1_valid;
    logic [DIV1_LANES-1:0][DIV1_Q_W-1:0]     w_q1;
    logic                                    w_q1_szero;

    clpc_div #(
        .NUM_W  (DIV1_NUM_W),
        .DEN_W  (DIV1_DEN_W),
        .Q_W    (DIV1_Q_W),
        .LANES  (DIV1_LANES),
        .SIDE_W (1)
    ) u_div_frac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p_valid),
        .i_num   (r_p_num),
        .i_den   ({DIV1_LANES{w_span}}),
        .i_side  (r_p_szero),
        .o_valid (w_q1_valid),
        .o_quo   (w_q1),
        .o_side  (w_q1_szero)
    );

    logic        r_f_valid;
    t_cal_side   r_f_side;
    logic [15:0] r_f_pos;
    logic [15:0] r_f_den;
    logic [15:0] r_f_mag;
    t_cal_side   n_f_side;
    logic [15:0] n_f_pos;
    logic [15:0] n_f_den;
    logic [15:0] w_lo;
    logic [15:0] w_hi;
    logic [15:0] w_q3;

    always_comb begin
        w_q3 = w_q1[3][15:0];
        n_f_side.level  = w_q1_szero ? 16'd0 : w_q1[0][15:0];
        n_f_side.height = w_q1_szero ? 24'd0 : w_q1[1];
        n_f_side.lin    = DAC_LOW_C + (w_q1_szero ? 16'd0 : w_q1[2][15:0]);
        if (w_q1_szero) begin
            n_f_side.direct = d0;
        end else if (w_dir_down) begin
            n_f_side.direct = d0 - w_q3;
        end else begin
            n_f_side.direct = d0 + w_q3;
        end
        n_f_pos = '0;
        n_f_den = '0;
        w_lo    = d0;
        w_hi    = d0;
        n_f_side.hold = 1'b0;
        n_f_side.hval = d0;
        if (n_f_side.level < a0) begin
            n_f_side.hold = 1'b1;
            n_f_side.hval = d0;
        end else if (n_f_side.level < a1) begin
            n_f_pos = n_f_side.level - a0;
            n_f_den = a1 - a0;
            w_lo    = d0;
            w_hi    = d1;
        end else if (n_f_side.level < a2) begin
            n_f_pos = n_f_side.level - a1;
            n_f_den = a2 - a1;
            w_lo    = d1;
            w_hi    = d2;
        end else if (n_f_side.level < a3) begin
            n_f_pos = n_f_side.level - a2;
            n_f_den = a3 - a2;
            w_lo    = d2;
            w_hi    = d3;
        end else begin
            n_f_side.hold = 1'b1;
            n_f_side.hval = d3;
        end
        n_f_side.dlo  = w_lo;
        n_f_side.down = w_hi < w_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= w_q1_valid;
        end
        if (w_en) begin
            r_f_side <= n_f_side;
            r_f_pos  <= n_f_pos;
            r_f_den  <= n_f_den;
            r_f_mag  <= n_f_side.down ? (w_lo - w_hi) : (w_hi - w_lo);
        end
    end

    logic        r_g_valid;
    t_cal_side   r_g_side;
    logic [31:0] r_g_prod;
    logic [15:0] r_g_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (w_en) begin
            r_g_valid <= r_f_valid;
        end
        if (w_en) begin
            r_g_side <= r_f_side;
            r_g_prod <= 32'(r_f_pos) * 32'(r_f_mag);
            r_g_den  <= r_f_den;
        end
    end

    logic                w_q2_valid;
    logic [DIV2_Q_W-1:0] w_q2;
    t_cal_side           w_q2_side;

    clpc_div #(
        .NUM_W  (DIV2_NUM_W),
        .DEN_W  (DIV2_DEN_W),
        .Q_W    (DIV2_Q_W),
        .LANES  (1),
        .SIDE_W ($bits(t_cal_side))
    ) u_div_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_g_valid),
        .i_num   (r_g_prod),
        .i_den   (r_g_den),
        .i_side  (r_g_side),
        .o_valid (w_q2_valid),
        .o_quo   (w_q2),
        .o_side  (w_q2_side)
    );

    logic [15:0] r_o_level;
    logic [23:0] r_o_height;
    logic [15:0] r_o_lin;
    logic [15:0] r_o_cal;
    logic [15:0] n_o_cal;

    always_comb begin
        if (w_uncal) begin
            n_o_cal = w_q2_side.direct;
        end else if (w_q2_side.hold) begin
            n_o_cal = w_q2_side.hval;
        end else if (w_q2_side.down) begin
            n_o_cal = w_q2_side.dlo - w_q2;
        end else begin
            n_o_cal = w_q2_side.dlo + w_q2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_q2_valid;
        end
        if (w_en) begin
            r_o_level  <= w_q2_side.level;
            r_o_height <= w_q2_side.height;
            r_o_lin    <= w_q2_side.lin;
            r_o_cal    <= n_o_cal;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_level_code     = r_o_level;
    assign o_height_q8      = r_o_height;
    assign o_dac_linear     = r_o_lin;
    assign o_dac_calibrated = r_o_cal;

endmodule

>>> hdl/clpc_chk.sv
`include "capacitance_level_piecewise_calibrator_macros.svh"

module clpc_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic [31:0]                     i_raw_reading,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [15:0]                     o_level_code,
    input logic [23:0]                     o_height_q8,
    input logic [15:0]                     o_dac_linear,
    input logic [15:0]                     o_dac_calibrated,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [clpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [clpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import clpc_pkg::*;

    // A stalled output word stays valid and unchanged.
    `CLPC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_level_code) && $stable(o_dac_calibrated) && $stable(o_height_q8))

    // The input side is held back only by a waiting output word.
    `CLPC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // The linear DAC code stays inside its range.
    `CLPC_ASSERT_IMP(a_lin_range, i_clk, i_rst_n, o_valid, o_dac_linear <= DAC_TOP)

    // Reset empties the pipeline.
    `CLPC_ASSERT_ALW(a_reset_empty, i_clk, !i_rst_n, !o_valid)

endmodule

bind capacitance_level_piecewise_calibrator clpc_chk u_clpc_chk (.*);

>>> tb/capacitance_level_piecewise_calibrator_tb.sv
module capacitance_level_piecewise_calibrator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clpc_pkg::*;

    typedef struct packed {
        logic [15:0] level;
        logic [23:0] height;
        logic [15:0] lin;
        logic [15:0] cal;
    } level_word_t;

    typedef struct {
        bit          is_write;
        logic [2:0]  index;
        logic [63:0] data;
        logic [31:0] raw;
        bit          known;
        level_word_t word;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_raw_reading = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_level_code;
    logic [23:0] o_height_q8;
    logic [15:0] o_dac_linear;
    logic [15:0] o_dac_calibrated;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    bit          comp_on;
    logic [15:0] gain;
    logic [15:0] offset;
    logic [31:0] cap_lo;
    logic [31:0] cap_hi;
    logic [15:0] height_full;
    logic [63:0] level_bp;
    logic [63:0] dac_bp;

    level_word_t pending_words[$];
    int          fail_count = 0;
    bit          calm = 1'b0;

    capacitance_level_piecewise_calibrator dut (.*);

    always #10 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [15:0] segment_point(longint unsigned pos, longint unsigned den,
                                                  logic [15:0] lo, logic [15:0] hi);
        if (den == 0) return lo;
        if (hi >= lo) return 16'(lo + (pos * (hi - lo)) / den);
        return 16'(lo - (pos * (lo - hi)) / den);
    endfunction

    function automatic level_word_t predict_level(logic [31:0] raw);
        level_word_t     w;
        longint unsigned corr;
        longint unsigned t;
        longint unsigned num;
        longint unsigned span;
        longint unsigned lin_span;
        logic [15:0]     a[4];
        logic [15:0]     d[4];
        logic [15:0]     lvl;
        num = 0;
        span = 0;
        w = '0;
        corr = raw;
        if (comp_on) begin
            t = longint'(raw) * gain + offset;
            if (t < 10000) corr = 0;
            else begin
                corr = (t - 10000) / 100;
                if (corr > 64'hFFFF_FFFF) corr = 64'hFFFF_FFFF;
            end
        end
        if (cap_hi > cap_lo) begin
            span = cap_hi - cap_lo;
            if (corr <= cap_lo) num = 0;
            else if (corr >= cap_hi) num = span;
            else num = corr - cap_lo;
            w.level = 16'((num * LEVEL_FULL) / span);
            w.height = 24'((num * height_full * 256) / span);
        end
        lin_span = (DAC_HIGH > DAC_LOW) ? DAC_HIGH - DAC_LOW : 0;
        w.lin = (span != 0) ? 16'(DAC_LOW + (num * lin_span) / span) : 16'(DAC_LOW);
        for (int i = 0; i < 4; i++) begin
            a[i] = level_bp[16*i +: 16];
            d[i] = dac_bp[16*i +: 16];
        end
        lvl = w.level;
        if (a[1] == 0 || d[2] == 0)
            w.cal = (span != 0) ? segment_point(num, span, d[0], d[3]) : d[0];
        else if (lvl < a[0]) w.cal = d[0];
        else if (lvl < a[1]) w.cal = segment_point(lvl - a[0], a[1] - a[0], d[0], d[1]);
        else if (lvl < a[2]) w.cal = segment_point(lvl - a[1], a[2] - a[1], d[1], d[2]);
        else if (lvl < a[3]) w.cal = segment_point(lvl - a[2], a[3] - a[2], d[2], d[3]);
        else w.cal = d[3];
        return w;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [63:0] data);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_COMP_ENABLE: comp_on = data[0];
            CFG_GAIN:        gain = data[15:0];
            CFG_OFFSET:      offset = data[15:0];
            CFG_CAP_EMPTY:   cap_lo = data[31:0];
            CFG_CAP_FULL:    cap_hi = data[31:0];
            CFG_HEIGHT_SPAN: height_full = data[15:0];
            CFG_LEVEL_BP:    level_bp = data;
            CFG_DAC_BP:      dac_bp = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_reading(logic [31:0] raw, bit known, level_word_t word);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_raw_reading = raw;
        do @(posedge i_clk); while (o_stall);
        pending_words.push_back(known ? word : predict_level(raw));
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned n;
        forever begin
            n = calm ? 0 : $urandom_range(0, 3);
            if (n != 0) begin
                i_stall = 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall = 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        level_word_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_words.size() == 0) begin
                $error("unexpected output word");
                fail_count++;
            end else begin
                e = pending_words.pop_front();
                if (o_level_code !== e.level) begin
                    $error("level_code expected %0d got %0d", e.level, o_level_code);
                    fail_count++;
                end
                if (o_height_q8 !== e.height) begin
                    $error("height_q8 expected %0d got %0d", e.height, o_height_q8);
                    fail_count++;
                end
                if (o_dac_linear !== e.lin) begin
                    $error("dac_linear expected %0d got %0d", e.lin, o_dac_linear);
                    fail_count++;
                end
                if (o_dac_calibrated !== e.cal) begin
                    $error("dac_calibrated expected %0d got %0d", e.cal, o_dac_calibrated);
                    fail_count++;
                end
            end
        end
    end

    function automatic stim_row_t reg_row(logic [2:0] index, logic [63:0] data);
        stim_row_t r;
        r = '{1'b1, index, data, 32'd0, 1'b0, '0};
        return r;
    endfunction

    function automatic stim_row_t item_row(logic [31:0] raw);
        stim_row_t r;
        r = '{1'b0, 3'd0, 64'd0, raw, 1'b0, '0};
        return r;
    endfunction

    function automatic stim_row_t known_row(logic [31:0] raw, level_word_t w);
        stim_row_t r;
        r = '{1'b0, 3'd0, 64'd0, raw, 1'b1, w};
        return r;
    endfunction

    function automatic logic [15:0] pick16(logic [15:0] typical);
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return typical;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_setup();
        logic [31:0]     lo;
        longint unsigned width;
        logic [15:0]     a[4];
        logic [15:0]     tmp;
        write_reg(CFG_COMP_ENABLE, 64'($urandom_range(0, 1)));
        write_reg(CFG_GAIN, 64'(pick16(16'd100)));
        write_reg(CFG_OFFSET, 64'(pick16(16'd10000)));
        lo = $urandom;
        width = 64'd1 << $urandom_range(0, 32);
        width = $urandom_range(0, 8) == 0 ? 0 : 64'($urandom) % width + 1;
        case ($urandom_range(0, 5))
            0: begin lo = 0; width = 64'hFFFF_FFFF; end
            1: lo = 0;
            default: ;
        endcase
        write_reg(CFG_CAP_EMPTY, 64'(lo));
        if ($urandom_range(0, 9) == 0) write_reg(CFG_CAP_FULL, 64'(lo - $urandom_range(0, 9)));
        else write_reg(CFG_CAP_FULL, (lo + width > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : lo + width);
        write_reg(CFG_HEIGHT_SPAN, 64'(pick16(16'(1000))));
        for (int i = 0; i < 4; i++) a[i] = $urandom;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3 - i; j++)
                if (a[j] > a[j+1]) begin
                    tmp = a[j]; a[j] = a[j+1]; a[j+1] = tmp;
                end
        if ($urandom_range(0, 3) == 0) a[0] = 0;
        if ($urandom_range(0, 5) == 0) a[1] = 0;
        write_reg(CFG_LEVEL_BP, {a[3], a[2], a[1], a[0]});
        write_reg(CFG_DAC_BP, $urandom_range(0, 5) == 0 ? {$urandom, 16'd0, 16'($urandom)}
                                                        : {$urandom, $urandom});
    endtask

    function automatic logic [31:0] random_reading();
        longint unsigned c;
        longint unsigned r;
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            1, 2: return $urandom;
            default: begin
                c = longint'(cap_lo) - 4 + $urandom_range(0, 8);
                if (cap_hi > cap_lo)
                    c = cap_lo - 4 + (64'($urandom) % (longint'(cap_hi - cap_lo) + 9));
                if (c > 64'hFFFF_FFFF) c = cap_lo;
                if (!comp_on || gain == 0) return 32'(c);
                r = (c * 100 + 10000 > offset) ? (c * 100 + 10000 - offset) / gain : 0;
                r = r + $urandom_range(0, 2) - 1;
                return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(r);
            end
        endcase
    endfunction

    initial begin
        stim_row_t   rows[$];
        int unsigned sent;
        int unsigned goal;
        comp_on = 1'b0;
        gain = 16'd100;
        offset = 16'd10000;
        cap_lo = 32'd0;
        cap_hi = 32'hFFFF_FFFF;
        height_full = 16'd0;
        level_bp = 64'd0;
        dac_bp = 64'd0;

        rows = '{
            known_row(32'd0, '{16'd0, 24'd0, 16'd0, 16'd0}),
            known_row(32'hFFFF_FFFF, '{16'hFFFF, 24'd0, 16'd4095, 16'd0}),
            item_row(32'h8000_0000),
            reg_row(CFG_HEIGHT_SPAN, 64'hFFFF),
            known_row(32'hFFFF_FFFF, '{16'hFFFF, 24'hFFFF00, 16'd4095, 16'd0}),
            item_row(32'h1234_5678),
            reg_row(CFG_CAP_EMPTY, 64'd1000),
            reg_row(CFG_CAP_FULL, 64'd1000),
            known_row(32'd5000, '{16'd0, 24'd0, 16'd0, 16'd0}),
            reg_row(CFG_CAP_FULL, 64'd500),
            known_row(32'hFFFF_FFFF, '{16'd0, 24'd0, 16'd0, 16'd0}),
            reg_row(CFG_CAP_FULL, 64'd2000),
            known_row(32'd10, '{16'd0, 24'd0, 16'd0, 16'd0}),
            known_row(32'd3000, '{16'hFFFF, 24'hFFFF00, 16'd4095, 16'd0}),
            item_row(32'd1500),
            reg_row(CFG_DAC_BP, {16'd4000, 16'd0, 16'd0, 16'd100}),
            item_row(32'd1500),
            known_row(32'd3000, '{16'hFFFF, 24'hFFFF00, 16'd4095, 16'd4000}),
            reg_row(CFG_DAC_BP, {16'd10, 16'd1000, 16'd3000, 16'd4000}),
            reg_row(CFG_LEVEL_BP, {16'd60000, 16'd40000, 16'd20000, 16'd1000}),
            known_row(32'd1000, '{16'd0, 24'd0, 16'd0, 16'd4000}),
            known_row(32'd3000, '{16'hFFFF, 24'hFFFF00, 16'd4095, 16'd10}),
            item_row(32'd1500),
            item_row(32'd1300),
            item_row(32'd1800),
            reg_row(CFG_COMP_ENABLE, 64'd1),
            reg_row(CFG_GAIN, 64'd0),
            reg_row(CFG_OFFSET, 64'd0),
            known_row(32'hFFFF_FFFF, '{16'd0, 24'd0, 16'd0, 16'd4000}),
            reg_row(CFG_GAIN, 64'hFFFF),
            reg_row(CFG_OFFSET, 64'hFFFF),
            known_row(32'hFFFF_FFFF, '{16'hFFFF, 24'hFFFF00, 16'd4095, 16'd10}),
            reg_row(CFG_GAIN, 64'd100),
            reg_row(CFG_OFFSET, 64'd10000),
            item_row(32'd1500),
            reg_row(CFG_GAIN, 64'd150),
            reg_row(CFG_OFFSET, 64'd5000),
            item_row(32'd1200),
            item_row(32'd1)
        };

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].is_write) begin
                i_valid = 1'b0;
                write_reg(rows[i].index, rows[i].data);
            end else begin
                send_reading(rows[i].raw, rows[i].known, rows[i].word);
            end
        end

        sent = 0;
        while (sent < 1800) begin
            i_valid = 1'b0;
            random_setup();
            calm = ($urandom_range(0, 3) == 0);
            goal = $urandom_range(60, 180);
            for (int k = 0; k < goal; k++) send_reading(random_reading(), 1'b0, '0);
            sent += goal;
        end
        i_valid = 1'b0;
        calm = 1'b0;

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
